FILE: rtl/dtpm_pkg.sv
// ----------------------------------------------------------------------------
// dtpm_pkg
// Shared types and constants of the decimal digit trie prefix matcher.
// ----------------------------------------------------------------------------
package dtpm_pkg;

  localparam int NODES   = 1024;
  localparam int NODE_W  = $clog2(NODES);
  localparam int FREE_W  = NODE_W + 1;
  localparam int RADIX   = 10;
  localparam int DIGIT_W = 4;
  localparam int BRAND_W = 8;
  localparam int STAT_W  = 2;

  localparam logic [DIGIT_W-1:0] DIGIT_MAX = DIGIT_W'(RADIX - 1);
  localparam logic [FREE_W-1:0]  POOL_END  = FREE_W'(NODES);

  localparam logic CMD_LOOKUP = 1'b0;
  localparam logic CMD_INSERT = 1'b1;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_BAD_DIGIT = 2'd1;
  localparam logic [STAT_W-1:0] ST_CONFLICT  = 2'd2;
  localparam logic [STAT_W-1:0] ST_POOL_FULL = 2'd3;

  typedef logic [NODE_W-1:0]             node_t;
  typedef logic [RADIX-1:0][NODE_W-1:0]  link_row_t;
  typedef logic [BRAND_W-1:0]            brand_t;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_WALK,
    S_BRAND,
    S_ALLOC,
    S_DONE
  } state_t;

  typedef struct packed {
    logic      link_we;
    node_t     link_waddr;
    link_row_t link_wdata;
    node_t     link_raddr;
    logic      brand_we;
    node_t     brand_waddr;
    brand_t    brand_wdata;
    node_t     brand_raddr;
  } store_req_t;

endpackage

FILE: rtl/dtpm_in_if.sv
// ----------------------------------------------------------------------------
// dtpm_in_if
// Digit channel: one digit of a lookup or insert sequence per transfer.
// ----------------------------------------------------------------------------
interface dtpm_in_if;
  logic                          valid;
  logic                          ready;
  logic                          cmd;
  logic [dtpm_pkg::DIGIT_W-1:0]  digit;
  logic                          last;
  logic [dtpm_pkg::BRAND_W-1:0]  brand_id;

  modport source (output valid, cmd, digit, last, brand_id, input ready);
  modport sink   (input valid, cmd, digit, last, brand_id, output ready);
endinterface

FILE: rtl/dtpm_out_if.sv
// ----------------------------------------------------------------------------
// dtpm_out_if
// Result channel: brand and status at the end of a sequence.
// ----------------------------------------------------------------------------
interface dtpm_out_if;
  logic                          valid;
  logic                          ready;
  logic [dtpm_pkg::BRAND_W-1:0]  brand;
  logic [dtpm_pkg::STAT_W-1:0]   status;

  modport source (output valid, brand, status, input ready);
  modport sink   (input valid, brand, status, output ready);
endinterface

FILE: rtl/dtpm_store.sv
// ----------------------------------------------------------------------------
// dtpm_store
// Node pool storage: one row of ten child links per node, plus node brands.
// ----------------------------------------------------------------------------
module dtpm_store (
  input  logic                   clk,
  input  dtpm_pkg::store_req_t   req,
  output dtpm_pkg::link_row_t    link_row,
  output dtpm_pkg::brand_t       brand_q
);
  import dtpm_pkg::*;

  link_row_t link_mem [NODES];
  brand_t    brand_mem [NODES];

  always_ff @(posedge clk) begin
    if (req.link_we) begin
      link_mem[req.link_waddr] <= req.link_wdata;
    end
    link_row <= link_mem[req.link_raddr];
  end

  always_ff @(posedge clk) begin
    if (req.brand_we) begin
      brand_mem[req.brand_waddr] <= req.brand_wdata;
    end
    brand_q <= brand_mem[req.brand_raddr];
  end

endmodule

FILE: rtl/digit_trie_prefix_match.sv
// steps: a digit is accepted in S_IDLE and walks the cursor row in S_WALK; a
// move to an existing node adds S_BRAND, an allocation adds S_ALLOC, and the
// final digit adds S_DONE to register the result, which waits for the output
// channel; a new digit is accepted only back in S_IDLE
// reset: after reset, S_INIT clears the root row; nodes are cleared as they
// are allocated, so the pool needs no full clearing pass
// ----------------------------------------------------------------------------
// digit_trie_prefix_match
// Decimal digit trie with longest-prefix brand lookup and brand insert.
// ----------------------------------------------------------------------------
module digit_trie_prefix_match (
  input  logic        clk,
  input  logic        rst_n,
  dtpm_in_if.sink     in_ch,
  dtpm_out_if.source  out_ch
);
  import dtpm_pkg::*;

  state_t             state_r, state_nxt;
  node_t              cursor_r, cursor_nxt;
  brand_t             best_r, best_nxt;
  brand_t             cur_brand_r, cur_brand_nxt;
  logic [FREE_W-1:0]  next_free_r, next_free_nxt;
  logic [STAT_W-1:0]  seq_err_r, seq_err_nxt;
  logic               fell_r, fell_nxt;

  logic               cmd_r;
  logic [DIGIT_W-1:0] digit_r;
  logic               last_r;
  brand_t             id_r;

  logic               out_valid_r, out_valid_nxt;
  brand_t             out_brand_r, out_brand_nxt;
  logic [STAT_W-1:0]  out_status_r, out_status_nxt;

  store_req_t         req;
  link_row_t          link_row;
  brand_t             brand_q;

  logic               digit_ok;
  node_t              child;
  logic               do_walk;
  logic               hit;
  logic               do_alloc;
  logic               out_free;
  logic               accept;

  dtpm_store u_store (
    .clk      (clk),
    .req      (req),
    .link_row (link_row),
    .brand_q  (brand_q)
  );

  assign accept   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign digit_ok = digit_r <= DIGIT_MAX;
  assign child    = digit_ok ? link_row[digit_r] : '0;
  assign do_walk  = (state_r == S_WALK) && (seq_err_r == ST_OK) && digit_ok && !fell_r;
  assign hit      = child != '0;
  assign do_alloc = do_walk && !hit && (cmd_r == CMD_INSERT) && (next_free_r != POOL_END);

  assign in_ch.ready   = state_r == S_IDLE;
  assign out_ch.valid  = out_valid_r;
  assign out_ch.brand  = out_brand_r;
  assign out_ch.status = out_status_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_INIT: begin
        state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_ch.valid) begin
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        if (do_walk && hit) begin
          state_nxt = S_BRAND;
        end else if (do_alloc) begin
          state_nxt = S_ALLOC;
        end else begin
          state_nxt = last_r ? S_DONE : S_IDLE;
        end
      end
      S_BRAND, S_ALLOC: begin
        state_nxt = last_r ? S_DONE : S_IDLE;
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_INIT;
      end
    endcase
  end

  // datapath and store control
  always_comb begin
    cursor_nxt     = cursor_r;
    best_nxt       = best_r;
    cur_brand_nxt  = cur_brand_r;
    next_free_nxt  = next_free_r;
    seq_err_nxt    = seq_err_r;
    fell_nxt       = fell_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_brand_nxt  = out_brand_r;
    out_status_nxt = out_status_r;

    req             = '0;
    req.link_raddr  = cursor_r;
    req.brand_raddr = child;

    case (state_r)
      S_INIT: begin
        // root row starts with no children
        req.link_we    = 1'b1;
        req.link_waddr = '0;
        req.link_wdata = '0;
      end
      S_WALK: begin
        if (seq_err_r == ST_OK) begin
          if (!digit_ok) begin
            seq_err_nxt = ST_BAD_DIGIT;
          end else if (fell_r) begin
            if (cmd_r == CMD_INSERT) begin
              seq_err_nxt = ST_BAD_DIGIT;
            end
          end else if (hit) begin
            cursor_nxt = child;
          end else if (cmd_r == CMD_LOOKUP) begin
            fell_nxt = 1'b1;
          end else if (next_free_r == POOL_END) begin
            seq_err_nxt = ST_POOL_FULL;
          end else begin
            // link the new node into the cursor row
            req.link_we             = 1'b1;
            req.link_waddr          = cursor_r;
            req.link_wdata          = link_row;
            req.link_wdata[digit_r] = next_free_r[NODE_W-1:0];
            cursor_nxt              = next_free_r[NODE_W-1:0];
            next_free_nxt           = next_free_r + 1'b1;
            cur_brand_nxt           = '0;
          end
        end
      end
      S_BRAND: begin
        cur_brand_nxt = brand_q;
        if (brand_q != '0) begin
          best_nxt = brand_q;
        end
      end
      S_ALLOC: begin
        // fresh node: no children, no brand
        req.link_we     = 1'b1;
        req.link_waddr  = cursor_r;
        req.link_wdata  = '0;
        req.brand_we    = 1'b1;
        req.brand_waddr = cursor_r;
        req.brand_wdata = '0;
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (seq_err_r != ST_OK) begin
            out_brand_nxt  = '0;
            out_status_nxt = seq_err_r;
          end else if (cmd_r == CMD_LOOKUP) begin
            out_brand_nxt  = best_r;
            out_status_nxt = ST_OK;
          end else if (cur_brand_r != '0) begin
            out_brand_nxt  = cur_brand_r;
            out_status_nxt = ST_CONFLICT;
          end else begin
            req.brand_we    = 1'b1;
            req.brand_waddr = cursor_r;
            req.brand_wdata = id_r;
            out_brand_nxt   = id_r;
            out_status_nxt  = ST_OK;
          end
          cursor_nxt    = '0;
          best_nxt      = '0;
          cur_brand_nxt = '0;
          seq_err_nxt   = ST_OK;
          fell_nxt      = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      cursor_r    <= '0;
      best_r      <= '0;
      cur_brand_r <= '0;
      next_free_r <= FREE_W'(1);
      seq_err_r   <= ST_OK;
      fell_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cursor_r    <= cursor_nxt;
      best_r      <= best_nxt;
      cur_brand_r <= cur_brand_nxt;
      next_free_r <= next_free_nxt;
      seq_err_r   <= seq_err_nxt;
      fell_r      <= fell_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r   <= in_ch.cmd;
      digit_r <= in_ch.digit;
      last_r  <= in_ch.last;
      id_r    <= in_ch.brand_id;
    end
    out_brand_r  <= out_brand_nxt;
    out_status_r <= out_status_nxt;
  end

  // the allocator never runs past the pool
  a_pool_bound: assert property (@(posedge clk) disable iff (!rst_n)
    next_free_r <= POOL_END)
    else $error("next free node beyond pool");

  // the cursor always sits on an allocated node
  a_cursor_alloc: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, cursor_r} < next_free_r)
    else $error("cursor on unallocated node");

  // a result appears only after the sequence end step
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result without sequence end");

  // error results carry no brand
  a_err_no_brand: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r == ST_BAD_DIGIT || out_status_r == ST_POOL_FULL)
      |-> out_brand_r == '0)
    else $error("brand on error result");

  // a new result is not loaded while the previous one waits
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |=> $stable(out_brand_r) && $stable(out_status_r))
    else $error("pending result overwritten");

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives lookup and insert digit sequences into the digit trie and compares
// every brand/status answer with an in-bench trie model or a typed answer.
// ----------------------------------------------------------------------------
module testbench;
  import dtpm_pkg::*;

  typedef logic [STAT_W-1:0] stat_t;

  typedef struct packed {
    logic               cmd;
    logic [DIGIT_W-1:0] digit;
    logic               last;
    brand_t             brand_id;
  } digit_item_t;

  typedef struct packed {
    digit_item_t it;
    logic        typed;
    brand_t      brand;
    stat_t       status;
  } dir_row_t;

  typedef struct packed {
    brand_t brand;
    stat_t  status;
  } answer_t;

  typedef struct packed {
    logic [4:0]                   len;
    logic [15:0][DIGIT_W-1:0]     d;
  } path_t;

  localparam int DIR_ROWS   = 23;
  localparam int RAND_ITEMS = 650;
  localparam int TAIL_ITEMS = 150;
  localparam int HOLD_START = 1500;
  localparam int HOLD_LEN   = 400;
  localparam int LIMIT      = 600000;

  logic clk;
  logic rst_n;

  dtpm_in_if  in_ch ();
  dtpm_out_if out_ch ();

  digit_trie_prefix_match i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // trie model state
  node_t             trie_link [NODES][RADIX];
  brand_t            trie_brand [NODES];
  node_t             walk_node;
  brand_t            walk_best;
  logic [FREE_W-1:0] pool_next;
  stat_t             walk_err;
  logic              walk_off;

  answer_t answer_q [$];
  path_t   saved_paths [$];
  int      fails;
  int      items_sent;
  int      burst_left;
  int      cycle_cnt;
  logic    row_typed;
  brand_t  row_brand;
  stat_t   row_status;

  // directed rows: typed answers where they are obvious, else the model decides
  dir_row_t dir_rows [DIR_ROWS] = '{
    '{'{CMD_LOOKUP, 4'd5,  1'b1, 8'h00}, 1'b1, 8'h00, ST_OK},
    '{'{CMD_INSERT, 4'd4,  1'b0, 8'hA5}, 1'b0, 8'h00, ST_OK},
    '{'{CMD_INSERT, 4'd5,  1'b1, 8'hA5}, 1'b1, 8'hA5, ST_OK},
    '{'{CMD_LOOKUP, 4'd4,  1'b0, 8'h00}, 1'b0, 8'h00, ST_OK},
    '{'{CMD_LOOKUP, 4'd5,  1'b0, 8'h00}, 1'b0, 8'h00, ST_OK},
    '{'{CMD_LOOKUP, 4'd9,  1'b1, 8'h00}, 1'b1, 8'hA5, ST_OK},
    '{'{CMD_INSERT, 4'd4,  1'b0, 8'h33}, 1'b0, 8'h00, ST_OK},
    '{'{CMD_INSERT, 4'd5,  1'b1, 8'h33}, 1'b1, 8'hA5, ST_CONFLICT},
    '{'{CMD_INSERT, 4'd4,  1'b0, 8'hA5}, 1'b0, 8'h00, ST_OK},
    '{'{CMD_INSERT, 4'd5,  1'b1, 8'hA5}, 1'b1, 8'hA5, ST_CONFLICT},
    '{'{CMD_INSERT, 4'd15, 1'b1, 8'h7E}, 1'b1, 8'h00, ST_BAD_DIGIT},
    '{'{CMD_INSERT, 4'd10, 1'b0, 8'h01}, 1'b0, 8'h00, ST_OK},
    '{'{CMD_INSERT, 4'd0,  1'b1, 8'h01}, 1'b1, 8'h00, ST_BAD_DIGIT},
    '{'{CMD_LOOKUP, 4'd0,  1'b0, 8'h00}, 1'b0, 8'h00, ST_OK},
    '{'{CMD_LOOKUP, 4'd7,  1'b0, 8'h00}, 1'b0, 8'h00, ST_OK},
    '{'{CMD_INSERT, 4'd1,  1'b1, 8'h07}, 1'b1, 8'h00, ST_BAD_DIGIT},
    '{'{CMD_INSERT, 4'd9,  1'b1, 8'h00}, 1'b1, 8'h00, ST_OK},
    '{'{CMD_INSERT, 4'd9,  1'b1, 8'hFF}, 1'b1, 8'hFF, ST_OK},
    '{'{CMD_LOOKUP, 4'd9,  1'b0, 8'h00}, 1'b0, 8'h00, ST_OK},
    '{'{CMD_LOOKUP, 4'd0,  1'b0, 8'h00}, 1'b0, 8'h00, ST_OK},
    '{'{CMD_LOOKUP, 4'd0,  1'b1, 8'h00}, 1'b1, 8'hFF, ST_OK},
    '{'{CMD_INSERT, 4'd4,  1'b0, 8'h12}, 1'b0, 8'h00, ST_OK},
    '{'{CMD_LOOKUP, 4'd5,  1'b1, 8'h12}, 1'b0, 8'h00, ST_OK}
  };

  function automatic void trie_clear();
    for (int n = 0; n < NODES; n++) begin
      for (int r = 0; r < RADIX; r++) trie_link[n][r] = '0;
      trie_brand[n] = '0;
    end
    pool_next = FREE_W'(1);
    walk_node = '0;
    walk_best = '0;
    walk_err  = ST_OK;
    walk_off  = 1'b0;
  endfunction

  // one digit through the trie; returns 1 when the digit ends a sequence
  function automatic bit trie_step(digit_item_t it, output brand_t rb, output stat_t rs);
    node_t child;
    rb = '0;
    rs = ST_OK;
    if (walk_err == ST_OK) begin
      if (it.digit > DIGIT_MAX) begin
        walk_err = ST_BAD_DIGIT;
      end else if (walk_off) begin
        if (it.cmd == CMD_INSERT) walk_err = ST_BAD_DIGIT;
      end else begin
        child = trie_link[walk_node][it.digit];
        if (child != '0) begin
          walk_node = child;
          if (trie_brand[child] != '0) walk_best = trie_brand[child];
        end else if (it.cmd == CMD_LOOKUP) begin
          walk_off = 1'b1;
        end else if (pool_next == POOL_END) begin
          walk_err = ST_POOL_FULL;
        end else begin
          child = node_t'(pool_next);
          pool_next = pool_next + 1'b1;
          for (int r = 0; r < RADIX; r++) trie_link[child][r] = '0;
          trie_brand[child] = '0;
          trie_link[walk_node][it.digit] = child;
          walk_node = child;
        end
      end
    end
    if (!it.last) return 1'b0;
    if (walk_err != ST_OK) begin
      rs = walk_err;
    end else if (it.cmd == CMD_LOOKUP) begin
      rb = walk_best;
    end else if (trie_brand[walk_node] != '0) begin
      rb = trie_brand[walk_node];
      rs = ST_CONFLICT;
    end else begin
      trie_brand[walk_node] = it.brand_id;
      rb = it.brand_id;
    end
    walk_node = '0;
    walk_best = '0;
    walk_err  = ST_OK;
    walk_off  = 1'b0;
    return 1'b1;
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT) begin
      $display("digit_trie_prefix_match regression: fail");
      $finish;
    end
  end

  // transfers are sampled here, before any register update of this edge
  always @(posedge clk) begin : scoreboard
    digit_item_t it;
    brand_t      pb;
    stat_t       ps;
    answer_t     exp_ans;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        it = '{in_ch.cmd, in_ch.digit, in_ch.last, in_ch.brand_id};
        if (trie_step(it, pb, ps)) begin
          if (row_typed) begin
            pb = row_brand;
            ps = row_status;
          end
          answer_q.push_back('{pb, ps});
        end
      end
      if (out_ch.valid && out_ch.ready) begin
        if (answer_q.size() == 0) begin
          $error("unexpected result: brand %0h status %0d", out_ch.brand, out_ch.status);
          fails++;
        end else begin
          exp_ans = answer_q.pop_front();
          if (out_ch.brand !== exp_ans.brand) begin
            $error("brand: expected %0h, got %0h", exp_ans.brand, out_ch.brand);
            fails++;
          end
          if (out_ch.status !== exp_ans.status) begin
            $error("status: expected %0d, got %0d", exp_ans.status, out_ch.status);
            fails++;
          end
        end
      end
    end
  end

  // receiver: random stall segments plus one long hold-off
  initial begin : receiver
    int seg;
    int mode;
    int rx_cyc;
    seg = 0;
    mode = 0;
    rx_cyc = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      rx_cyc++;
      if (seg == 0) begin
        seg = $urandom_range(1, 40);
        mode = $urandom_range(0, 3);
      end
      seg--;
      if (rx_cyc >= HOLD_START && rx_cyc < HOLD_START + HOLD_LEN) begin
        out_ch.ready <= 1'b0;
      end else begin
        case (mode)
          1: begin
            out_ch.ready <= 1'($urandom_range(0, 1));
          end
          2: begin
            out_ch.ready <= ($urandom_range(0, 7) == 0);
          end
          default: begin
            out_ch.ready <= 1'b1;
          end
        endcase
      end
    end
  end

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_item(digit_item_t it, logic typed = 1'b0, brand_t tb = '0,
                           stat_t ts = ST_OK);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    in_ch.valid    <= 1'b1;
    in_ch.cmd      <= it.cmd;
    in_ch.digit    <= it.digit;
    in_ch.last     <= it.last;
    in_ch.brand_id <= it.brand_id;
    row_typed  = typed;
    row_brand  = tb;
    row_status = ts;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_path(path_t p, logic cmd, brand_t id);
    digit_item_t it;
    for (int i = 0; i < int'(p.len); i++) begin
      it = '{cmd, p.d[i], (i == int'(p.len) - 1), id};
      send_item(it);
    end
  endtask

  function automatic path_t rand_path(int len, bit wide);
    path_t p;
    p = '0;
    p.len = 5'(len);
    for (int i = 0; i < len; i++)
      p.d[i] = wide ? 4'($urandom_range(0, 9)) : 4'($urandom_range(0, 3));
    return p;
  endfunction

  function automatic brand_t rand_brand();
    return ($urandom_range(0, 15) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
  endfunction

  // one random sequence, often built around paths already inserted
  task automatic send_random_seq();
    int          pick;
    int          n;
    path_t       p;
    digit_item_t it;
    pick = $urandom_range(0, 99);
    if (pick < 30 || saved_paths.size() == 0) begin
      p = rand_path($urandom_range(1, 6), $urandom_range(0, 4) == 0);
      saved_paths.push_back(p);
      send_path(p, CMD_INSERT, rand_brand());
    end else if (pick < 75) begin
      p = saved_paths[$urandom_range(0, saved_paths.size() - 1)];
      n = $urandom_range(0, 2);
      if (n == 1) begin
        p.len = 5'($urandom_range(1, int'(p.len)));
      end else if (n == 2) begin
        n = $urandom_range(1, 4);
        while (n > 0 && p.len < 16) begin
          p.d[p.len[3:0]] = 4'($urandom_range(0, 9));
          p.len = p.len + 1'b1;
          n--;
        end
      end
      // mostly lookups, some re-inserts for conflicts and prefix brands
      send_path(p, (pick < 65) ? CMD_LOOKUP : CMD_INSERT, 8'($urandom_range(0, 255)));
    end else if (pick < 85) begin
      p = rand_path($urandom_range(1, 8), 1'b1);
      send_path(p, CMD_LOOKUP, 8'($urandom_range(0, 255)));
    end else if (pick < 93) begin
      p = rand_path($urandom_range(1, 5), 1'b0);
      p.d[$urandom_range(0, int'(p.len) - 1)] = 4'($urandom_range(10, 15));
      send_path(p, 1'($urandom_range(0, 1)), rand_brand());
    end else begin
      // per-digit command mix
      n = $urandom_range(1, 6);
      for (int i = 0; i < n; i++) begin
        it = '{1'($urandom_range(0, 1)), 4'($urandom_range(0, 4)), (i == n - 1),
               rand_brand()};
        send_item(it);
      end
    end
  endtask

  initial begin : main
    int    stop_at;
    rst_n = 1'b0;
    cycle_cnt = 0;
    fails = 0;
    items_sent = 0;
    burst_left = 0;
    row_typed = 1'b0;
    row_brand = '0;
    row_status = ST_OK;
    in_ch.valid = 1'b0;
    in_ch.cmd = CMD_LOOKUP;
    in_ch.digit = '0;
    in_ch.last = 1'b0;
    in_ch.brand_id = '0;
    trie_clear();
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIR_ROWS; i++)
      send_item(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].brand, dir_rows[i].status);

    while (items_sent < DIR_ROWS + RAND_ITEMS) send_random_seq();

    stop_at = items_sent + TAIL_ITEMS;
    while (items_sent < stop_at) send_random_seq();
    in_ch.valid <= 1'b0;

    while (answer_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fails == 0) begin
      $display("digit_trie_prefix_match regression: pass");
    end else begin
      $display("digit_trie_prefix_match regression: fail");
    end
    $finish;
  end

endmodule

FILE: digit_trie_prefix_match.f
rtl/dtpm_pkg.sv
rtl/dtpm_in_if.sv
rtl/dtpm_out_if.sv
rtl/dtpm_store.sv
rtl/digit_trie_prefix_match.sv
dv/testbench.sv
